// File: hw/rtl/atan2_pkg.sv
// Package for the atan2 block: widths, partition edges, cotangents,
// base angles and polynomial coefficients. No dependencies.
package atan2_pkg;
	localparam int CoordBits = 16;
	localparam int MagBits = CoordBits;
	localparam int AngleFracBits = 28;
	localparam int AngleBits = AngleFracBits + 3;
	localparam int QuoBits = 32;
	localparam int NumBits = MagBits + 34;
	localparam int DivSteps = 4;
	localparam int DivStages = QuoBits / DivSteps;

	localparam logic [63:0] TLimit = 64'd1073741823;
	localparam logic signed [35:0] PiQ = 36'sd13493037705;
	localparam logic signed [35:0] HalfPiQ = 36'sd6746518852;

	typedef logic [MagBits-1:0] mag_t;
	typedef logic [NumBits-1:0] num_t;

	// Control and sign data that travels with each item.
	typedef struct packed {
		logic yn;
		logic xn;
		logic xzero;
		logic undef;
		logic tneg;
		logic [3:0] part;
	} ctl_t;

	function automatic logic [32:0] edge_q(input int m);
		case (m)
			1: edge_q = 33'd105754339;
			2: edge_q = 33'd325716021;
			3: edge_q = 33'd573926962;
			4: edge_q = 33'd881197142;
			5: edge_q = 33'd1308358198;
			6: edge_q = 33'd2008829661;
			default: edge_q = 33'd3539652424;
		endcase
	endfunction

	function automatic logic [32:0] cot_q(input logic [3:0] r);
		case (r)
			4'd2: cot_q = 33'd5398064676;
			4'd3: cot_q = 33'd2592242074;
			4'd4: cot_q = 33'd1606968201;
			4'd5: cot_q = 33'd1073741824;
			4'd6: cot_q = 33'd717451349;
			4'd7: cot_q = 33'd444758426;
			4'd8: cot_q = 33'd213580528;
			default: cot_q = 33'd0;
		endcase
	endfunction

	function automatic logic signed [35:0] base_q(input logic [3:0] r);
		case (r)
			4'd2: base_q = 36'sd843314857;
			4'd3: base_q = 36'sd1686629713;
			4'd4: base_q = 36'sd2529944570;
			4'd5: base_q = 36'sd3373259426;
			4'd6: base_q = 36'sd4216574283;
			4'd7: base_q = 36'sd5059889139;
			4'd8: base_q = 36'sd5903203996;
			default: base_q = 36'sd0;
		endcase
	endfunction

	function automatic logic signed [35:0] coef_q(input int i);
		case (i)
			0: coef_q = 36'sd4294967296;
			1: coef_q = -36'sd1431655765;
			2: coef_q = 36'sd858993458;
			3: coef_q = -36'sd613566241;
			4: coef_q = 36'sd477115869;
			default: coef_q = -36'sd380988525;
		endcase
	endfunction

	// sign(a) * round(|a| * b / 2^32), ties away from zero.
	function automatic logic signed [35:0] mul_q32(input logic signed [35:0] a,
			input logic [31:0] b);
		logic neg;
		logic [35:0] mag;
		logic [67:0] prod;
		logic [35:0] res;
		neg = a[35];
		mag = neg ? 36'(-a) : 36'(a);
		prod = mag * b + 68'h0_8000_0000;
		res = prod[67:32];
		mul_q32 = neg ? -$signed(res) : $signed(res);
	endfunction
endpackage

// File: hw/rtl/atan2_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface atan2_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/atan2_div.sv
// One stage of the restoring fractional divider: DivSteps quotient bits.
// Depends on atan2_pkg.
module atan2_div (
	input logic [atan2_pkg::NumBits-1:0] rem_in,
	input logic [atan2_pkg::NumBits-1:0] den,
	input logic [atan2_pkg::QuoBits-1:0] quo_in,
	output logic [atan2_pkg::NumBits-1:0] rem_out,
	output logic [atan2_pkg::QuoBits-1:0] quo_out
);
	import atan2_pkg::*;

	// Each step doubles the remainder and subtracts the divisor when it fits.
	always_comb begin
		logic [NumBits-1:0] r;
		logic [QuoBits-1:0] q;
		r = rem_in;
		q = quo_in;
		for (int i = 0; i < DivSteps; i++) begin
			if (r >= den - r) begin
				r = r - (den - r);
				q = {q[QuoBits-2:0], 1'b1};
			end else begin
				r = r + r;
				q = {q[QuoBits-2:0], 1'b0};
			end
		end
		rem_out = r;
		quo_out = q;
	end
endmodule

// File: hw/rtl/atan2_polynomial_approx_top.sv
// Top level of the pipelined atan2 block.
// Depends on atan2_pkg, atan2_if and atan2_div.
//
// Computes atan2(y_coord, x_coord) in radians, Q.28, one item per clock when
// the output does not stall. The pipeline holds the divider (8 stages of
// 4 bits) and the polynomial (one Horner step per stage). A stall on the
// output holds the whole pipeline; no item is lost or repeated.
module atan2_polynomial_approx_top (
	input logic clk,
	input logic arst_n,
	atan2_if.sink in_ch,
	atan2_if.source out_ch
);
	import atan2_pkg::*;

	localparam int Lat = 4 + DivStages + 10;

	logic adv;
	logic [Lat-1:0] vld_q;
	assign adv = !vld_q[Lat-1] || out_ch.ready;
	assign in_ch.ready = adv;

	// Valid bits shift with the data when the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Lat-2:0], in_ch.valid};
		end
	end

	// Stage 1: split signs and magnitudes.
	logic signed [CoordBits-1:0] yin, xin;
	assign yin = in_ch.data.y_coord;
	assign xin = in_ch.data.x_coord;
	mag_t ya_s1, xa_s1;
	ctl_t ctl_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ya_s1 <= yin[CoordBits-1] ? mag_t'(-yin) : mag_t'(yin);
			xa_s1 <= xin[CoordBits-1] ? mag_t'(-xin) : mag_t'(xin);
			ctl_s1.yn <= yin[CoordBits-1];
			ctl_s1.xn <= xin[CoordBits-1];
			ctl_s1.xzero <= (xin == '0);
			ctl_s1.undef <= (xin == '0) && (yin == '0);
			ctl_s1.tneg <= 1'b0;
			ctl_s1.part <= 4'd0;
		end
	end

	// Stage 2: partition by cross-multiplied compares.
	mag_t ya_s2, xa_s2;
	ctl_t ctl_s2;
	ctl_t ctl_s2_d;
	always_comb begin
		logic [3:0] r;
		r = 4'd1;
		for (int m = 1; m <= 7; m++) begin
			if (num_t'({ya_s1, 30'd0}) >= num_t'(edge_q(m)) * num_t'(xa_s1))
				r = r + 4'd1;
		end
		ctl_s2_d = ctl_s1;
		ctl_s2_d.part = r;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ya_s2 <= ya_s1;
			xa_s2 <= xa_s1;
			ctl_s2 <= ctl_s2_d;
		end
	end

	// Stage 3: products d*|y| and d*|x|.
	num_t dy_s3, dx_s3;
	mag_t ya_s3, xa_s3;
	ctl_t ctl_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			dy_s3 <= num_t'(cot_q(ctl_s2.part)) * num_t'(ya_s2);
			dx_s3 <= num_t'(cot_q(ctl_s2.part)) * num_t'(xa_s2);
			ya_s3 <= ya_s2;
			xa_s3 <= xa_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: numerator, denominator and sign of t; clamp numerator.
	num_t rem_s4, den_s4;
	ctl_t ctl_s4;
	num_t num_d, den_d;
	ctl_t ctl_s4_d;
	always_comb begin
		num_t a, b, n, d;
		a = dy_s3;
		b = num_t'({xa_s3, 30'd0});
		ctl_s4_d = ctl_s3;
		if (ctl_s3.part == 4'd1) begin
			n = num_t'(ya_s3);
			d = num_t'(xa_s3);
			ctl_s4_d.tneg = 1'b0;
		end else begin
			ctl_s4_d.tneg = a < b;
			n = (a < b) ? b - a : a - b;
			d = dx_s3 + num_t'({ya_s3, 30'd0});
		end
		if (n >= d) n = d - num_t'(1);
		num_d = n;
		den_d = d;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s4 <= num_d;
			den_s4 <= den_d;
			ctl_s4 <= ctl_s4_d;
		end
	end

	// Divider stages.
	num_t rem_q [DivStages+1];
	num_t den_q [DivStages+1];
	logic [QuoBits-1:0] quo_q [DivStages+1];
	ctl_t ctl_q [DivStages+1];
	assign rem_q[0] = rem_s4;
	assign den_q[0] = den_s4;
	assign quo_q[0] = '0;
	assign ctl_q[0] = ctl_s4;
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		num_t r_n;
		logic [QuoBits-1:0] q_n;
		atan2_div u_div (
			.rem_in(rem_q[g]), .den(den_q[g]), .quo_in(quo_q[g]),
			.rem_out(r_n), .quo_out(q_n)
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[g+1] <= r_n;
				den_q[g+1] <= den_q[g];
				quo_q[g+1] <= q_n;
				ctl_q[g+1] <= ctl_q[g];
			end
		end
	end

	// Clamp t and square it.
	logic [31:0] t_s5, s_s5;
	ctl_t ctl_s5;
	logic [31:0] t_d, s_d;
	always_comb begin
		logic [QuoBits-1:0] tq;
		logic [63:0] sq;
		tq = (den_q[DivStages] == '0) ? '0 : quo_q[DivStages];
		if (64'(tq) > TLimit) tq = QuoBits'(TLimit);
		t_d = tq;
		sq = tq * tq + 64'h8000_0000;
		s_d = sq[63:32];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s5 <= t_d;
			s_s5 <= s_d;
			ctl_s5 <= ctl_q[DivStages];
		end
	end

	// Horner stages: one multiply and add per stage.
	logic signed [35:0] p_q [6];
	logic [31:0] tp_q [6], sp_q [6];
	ctl_t cp_q [6];
	assign p_q[0] = coef_q(5);
	assign tp_q[0] = t_s5;
	assign sp_q[0] = s_s5;
	assign cp_q[0] = ctl_s5;
	for (genvar h = 0; h < 5; h++) begin : g_horn
		always_ff @(posedge clk) begin
			if (adv) begin
				p_q[h+1] <= mul_q32(p_q[h], sp_q[h]) + coef_q(4 - h);
				tp_q[h+1] <= tp_q[h];
				sp_q[h+1] <= sp_q[h];
				cp_q[h+1] <= cp_q[h];
			end
		end
	end

	// Final multiply by t.
	logic signed [35:0] at_s6;
	ctl_t ctl_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			at_s6 <= mul_q32(p_q[5], tp_q[5]);
			ctl_s6 <= cp_q[5];
		end
	end

	// Base angle plus or minus the correction.
	logic signed [35:0] th_s7;
	ctl_t ctl_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			th_s7 <= base_q(ctl_s6.part) + (ctl_s6.tneg ? -at_s6 : at_s6);
			ctl_s7 <= ctl_s6;
		end
	end

	// Quadrant fix-up.
	logic signed [35:0] ang_s8;
	ctl_t ctl_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s7.xzero) ang_s8 <= ctl_s7.yn ? -HalfPiQ : HalfPiQ;
			else if (!ctl_s7.xn) ang_s8 <= ctl_s7.yn ? -th_s7 : th_s7;
			else ang_s8 <= ctl_s7.yn ? th_s7 - PiQ : PiQ - th_s7;
			ctl_s8 <= ctl_s7;
		end
	end

	// Rounding to the output format, into the output register.
	logic [AngleBits-1:0] ang_out_s9;
	logic undef_s9;
	logic [AngleBits-1:0] rnd_d;
	always_comb begin
		logic [35:0] mag;
		logic [35:0] rm;
		mag = ang_s8[35] ? 36'(-ang_s8) : 36'(ang_s8);
		rm = (mag + 36'(1 << (31 - AngleFracBits))) >> (32 - AngleFracBits);
		rnd_d = ang_s8[35] ? AngleBits'(-rm) : AngleBits'(rm);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_out_s9 <= ctl_s8.undef ? '0 : rnd_d;
			undef_s9 <= ctl_s8.undef;
		end
	end

	assign out_ch.valid = vld_q[Lat-1];
	assign out_ch.data.angle = $signed(ang_out_s9);
	assign out_ch.data.undefined = undef_s9;

`ifndef SYNTHESIS
	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(ang_out_s9))
		else $error("result changed under stall");
	// The undefined flag always comes with a zero angle.
	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && undef_s9 |-> ang_out_s9 == '0)
		else $error("undefined result with nonzero angle");
	// Input is taken whenever the output stage is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[Lat-1] |-> in_ch.ready)
		else $error("pipeline stalled without cause");
`endif
endmodule

// File: dv/atan2_tb_pkg.sv
// Payload types shared by the atan2 testbench files.
// Depends on atan2_pkg for the coordinate and angle widths.
`timescale 1ns / 100ps
package atan2_tb_pkg;
	import atan2_pkg::*;

	typedef struct packed {
		logic signed [CoordBits-1:0] y_coord;
		logic signed [CoordBits-1:0] x_coord;
	} vec_t;

	typedef struct packed {
		logic signed [AngleBits-1:0] angle;
		logic undefined;
	} angle_t;
endpackage

// File: dv/atan2_checker.sv
// Checker for the atan2 block: predicts each angle from the accepted vector
// and compares it with the output stream. Depends on atan2_pkg, atan2_tb_pkg.
`timescale 1ns / 100ps
module atan2_checker
	import atan2_pkg::*;
	import atan2_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	atan2_if in_ch,
	atan2_if out_ch,
	output int fail_count,
	output int pending,
	output int checked
);
	localparam longint unsigned EdgeQ[8] = '{64'd0, 64'd105754339, 64'd325716021,
		64'd573926962, 64'd881197142, 64'd1308358198, 64'd2008829661,
		64'd3539652424};
	localparam longint unsigned CotQ[9] = '{64'd0, 64'd0, 64'd5398064676,
		64'd2592242074, 64'd1606968201, 64'd1073741824, 64'd717451349,
		64'd444758426, 64'd213580528};
	localparam longint BaseQ[9] = '{64'sd0, 64'sd0, 64'sd843314857,
		64'sd1686629713, 64'sd2529944570, 64'sd3373259426, 64'sd4216574283,
		64'sd5059889139, 64'sd5903203996};
	localparam longint CoefQ[6] = '{64'sd4294967296, -64'sd1431655765,
		64'sd858993458, -64'sd613566241, 64'sd477115869, -64'sd380988525};
	localparam longint PiQ64 = 64'sd13493037705;
	localparam longint HalfPiQ64 = 64'sd6746518852;

	angle_t expected_angles[$];

	// Signed product with a Q.32 fraction, rounded half away from zero.
	function automatic longint scale_q32(longint a, longint unsigned b);
		longint unsigned mag;
		longint unsigned prod;
		mag = (a < 0) ? longint'(-a) : a;
		prod = (mag * b + 64'h8000_0000) >> 32;
		return (a < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// Restoring fraction divide: floor(n * 2^32 / den), numerator clamped.
	function automatic longint unsigned quotient_q32(longint unsigned n,
			longint unsigned den);
		longint unsigned rem;
		longint unsigned q;
		q = 0;
		if (den == 0)
			return 0;
		rem = (n >= den) ? den - 1 : n;
		for (int i = 0; i < 32; i++) begin
			if (rem >= den - rem) begin
				rem = rem - (den - rem);
				q = (q << 1) | 1;
			end else begin
				rem = rem + rem;
				q = q << 1;
			end
		end
		return q;
	endfunction

	function automatic angle_t predict_angle(vec_t v);
		angle_t res;
		logic yn, xn, tneg, aneg;
		longint unsigned ya, xa, t, s, amag, num_a, num_b, den;
		longint p, theta, ang;
		int part;
		yn = v.y_coord[CoordBits-1];
		xn = v.x_coord[CoordBits-1];
		ya = yn ? longint'(65536 - longint'($unsigned(v.y_coord))) : $unsigned(v.y_coord);
		xa = xn ? longint'(65536 - longint'($unsigned(v.x_coord))) : $unsigned(v.x_coord);
		res.undefined = 1'b0;
		tneg = 1'b0;
		part = 1;
		if (xa == 0) begin
			if (ya == 0) begin
				res.angle = '0;
				res.undefined = 1'b1;
				return res;
			end
			ang = yn ? -HalfPiQ64 : HalfPiQ64;
		end else begin
			// Pick the tangent partition by cross-multiplied compares.
			for (int m = 1; m <= 7; m++)
				if ((ya << 30) >= EdgeQ[m] * xa)
					part++;
			if (part == 1) begin
				t = quotient_q32(ya, xa);
			end else begin
				num_a = CotQ[part] * ya;
				num_b = xa << 30;
				den = CotQ[part] * xa + (ya << 30);
				tneg = num_a < num_b;
				t = quotient_q32(tneg ? num_b - num_a : num_a - num_b, den);
			end
			if (t > TLimit)
				t = TLimit;
			s = (t * t + 64'h8000_0000) >> 32;
			p = CoefQ[5];
			for (int i = 4; i >= 0; i--)
				p = scale_q32(p, s) + CoefQ[i];
			p = scale_q32(p, t);
			theta = BaseQ[part] + (tneg ? -p : p);
			if (!xn)
				ang = yn ? -theta : theta;
			else
				ang = yn ? theta - PiQ64 : PiQ64 - theta;
		end
		aneg = ang < 0;
		amag = aneg ? longint'(-ang) : ang;
		amag = (amag + (64'd1 << (31 - AngleFracBits))) >> (32 - AngleFracBits);
		res.angle = AngleBits'(aneg ? -longint'(amag) : longint'(amag));
		return res;
	endfunction

	assign pending = expected_angles.size();

	// Predict on each input transfer and compare on each output transfer.
	always @(posedge clk or negedge arst_n) begin
		angle_t got, want;
		if (!arst_n) begin
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_angles.push_back(predict_angle(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_angles.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result: angle=%0d undefined=%0b",
							got.angle, got.undefined);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_angles.pop_front();
					checked <= checked + 1;
					if (got.angle !== want.angle || got.undefined !== want.undefined) begin
						if (fail_count < 10)
							$display("Mismatch: angle exp=%0d got=%0d, undefined exp=%0b got=%0b",
								want.angle, got.angle, want.undefined, got.undefined);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: dv/tb_atan2_polynomial_approx_top.sv
// Top of the atan2 testbench: clock, reset, vector stimulus and verdict.
// Depends on atan2_pkg, atan2_if, atan2_tb_pkg and atan2_checker.
`timescale 1ns / 100ps
module tb_atan2_polynomial_approx_top;
	import atan2_pkg::*;
	import atan2_tb_pkg::*;

	localparam int NumRandom = 600;
	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 60;
	localparam int HoldOffCycles = 300;

	typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_e;

	logic clk;
	logic arst_n;
	int fail_count, pending, checked;
	int sent;
	int cycles;
	int hold_count;
	phase_e phase;
	vec_t directed_vecs[$];

	atan2_if #(.T(vec_t)) in_ch();
	atan2_if #(.T(angle_t)) out_ch();

	atan2_polynomial_approx_top uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	atan2_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic vec_t make_vec(int y, int x);
		vec_t v;
		v.y_coord = CoordBits'(y);
		v.x_coord = CoordBits'(x);
		return v;
	endfunction

	// Random vectors: full range mostly, with small, axis and extreme values.
	function automatic logic [CoordBits-1:0] random_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CoordBits'($urandom_range(0, 6) - 3);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			3: return CoordBits'($urandom_range(0, 200) - 100);
			default: return CoordBits'($urandom);
		endcase
	endfunction

	// Phase follows the number of items sent so far.
	always_comb begin
		if (sent < 120)
			phase = PH_FREE;
		else if (sent < 270)
			phase = PH_SEND_IDLE;
		else if (sent < 420)
			phase = PH_RECV_STALL;
		else if (sent < 560)
			phase = PH_BOTH;
		else
			phase = PH_HOLD;
	end

	// Sender: offer the next vector once the last one was taken, except in idle gaps.
	always @(posedge clk or negedge arst_n) begin
		logic idle;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			sent <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid)
				sent <= sent + 1;
			idle = (phase == PH_SEND_IDLE && $urandom_range(0, 99) < 78)
				|| (phase == PH_BOTH && $urandom_range(0, 99) < 9);
			if (sent + in_ch.valid >= directed_vecs.size() + NumRandom || idle) begin
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid <= 1'b1;
				if (sent + in_ch.valid < directed_vecs.size())
					in_ch.data <= directed_vecs[sent + in_ch.valid];
				else
					in_ch.data <= make_vec(random_coord(), random_coord());
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the pipeline fills.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_count <= 0;
		end else if (phase == PH_HOLD && hold_count < HoldOffCycles) begin
			hold_count <= hold_count + 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !((phase == PH_RECV_STALL && $urandom_range(0, 99) < 78)
				|| (phase == PH_BOTH && $urandom_range(0, 99) < 9));
		end
	end

	// Watchdog on total run length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CycleLimit) begin
				$display("Timeout after %0d cycles", cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		// Axes, origin, extremes, each quadrant and the most negative values.
		directed_vecs = '{make_vec(0, 0), make_vec(0, 1), make_vec(1, 0),
			make_vec(0, -1), make_vec(-1, 0), make_vec(5, -3), make_vec(-5, -3),
			make_vec(-5, 3), make_vec(0, -5), make_vec(5, 0),
			make_vec(32767, 32767), make_vec(-32768, -32768),
			make_vec(-32768, 0), make_vec(0, -32768), make_vec(32767, -32768),
			make_vec(-32768, 32767), make_vec(1, 32767), make_vec(32767, 1),
			make_vec(-1, -32768), make_vec(-32768, -1), make_vec(1, -1),
			make_vec(-1, 1), make_vec(3, 5), make_vec(100, 7)};
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent == directed_vecs.size() + NumRandom);
		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);
		$display("Checked %0d angles over free-running, idle, stall and hold-off phases.",
			checked);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
